/* src/htgm_pkg.sv */
// ----------------------------------------------------------------------------
// htgm_pkg
// Shared types and constants of the harmonic tremolo gain matrix: register
// indexes and reset values, the register file layout and the divider step.
// ----------------------------------------------------------------------------
package htgm_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_AMOUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_BIAS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAT_AMOUNT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASS_DEPTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TREBLE_DEPTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_BALANCE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STEREO_SPREAD = 3'd6;

   typedef struct packed {
      logic        [14:0] mod_amount;
      logic signed [15:0] mod_bias;
      logic        [14:0] sat_amount;
      logic signed [15:0] bass_depth;
      logic signed [15:0] treble_depth;
      logic signed [15:0] tone_balance;
      logic        [14:0] stereo_spread;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mod_amount:    15'd16384,
      mod_bias:      16'sd0,
      sat_amount:    15'd12288,
      bass_depth:    16'sd16384,
      treble_depth:  -16'sd16384,
      tone_balance:  16'sd0,
      stereo_spread: 15'd0
   };

   // smallest saturation strength, stands for the 1e-4 floor
   localparam logic [14:0] SAT_FLOOR = 15'd2;

   // long division: dividend shifts out the top, quotient bits shift in below
   localparam int unsigned DIV_W              = 32;
   localparam int unsigned DIV_BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

   typedef struct packed {
      logic [DIV_W-1:0] bits;
      logic [14:0]      rem;
   } div_type;

   function automatic div_type div_step(input div_type x, input logic [14:0] dvs);
      div_type     r;
      logic [15:0] trial;
      r = x;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
         trial = {r.rem, r.bits[DIV_W-1]};
         if (trial >= {1'b0, dvs}) begin
            r.rem  = 15'(trial - {1'b0, dvs});
            r.bits = {r.bits[DIV_W-2:0], 1'b1};
         end else begin
            r.rem  = trial[14:0];
            r.bits = {r.bits[DIV_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* src/harmonic_tremolo_gain_matrix_unit.sv */
// ----------------------------------------------------------------------------
// harmonic_tremolo_gain_matrix_unit
// Turns one LFO word into four band gains (bass and treble, left and right)
// with soft-saturated volume, stereo crossfade and tone weighting.
// ----------------------------------------------------------------------------
// Fully pipelined: a word is taken on every clock at which start is high and
// busy is low (busy is high only while reset is held), and its four gains
// appear with rsp_strobe high for one cycle. The receiver cannot stall, so
// there is no backpressure anywhere. The divider of the saturation curve, 8
// stages of 4 quotient bits each, is the largest part of the depth. Tone
// weights come from the registers in a free-running 4-stage chain; the
// user must write registers only while no word is in flight (not enforced).
module harmonic_tremolo_gain_matrix_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [15:0]                  req_lfo_value,
   output logic                                rsp_strobe,
   output logic signed [19:0]                  rsp_bass_gain_left,
   output logic signed [19:0]                  rsp_bass_gain_right,
   output logic signed [19:0]                  rsp_treble_gain_left,
   output logic signed [19:0]                  rsp_treble_gain_right,
   input  logic                                csr_write_enable,
   input  logic [htgm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [htgm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned LATENCY = 23;
   localparam int unsigned POS     = 0;
   localparam int unsigned NEG     = 1;
   localparam int unsigned BASS    = 0;
   localparam int unsigned TREB    = 1;
   localparam int unsigned LANES   = 4;

   localparam logic [28:0]        ONE_Q28 = 29'h1000_0000;
   localparam logic [57:0]        ONE_Q56 = 58'd1 << 56;
   localparam logic signed [48:0] ONE_Q42 = 49'sd1 <<< 42;
   localparam logic signed [19:0] OUT_MAX = 20'sd524287;
   localparam logic signed [19:0] OUT_MIN = -20'sd524288;

   // control
   htgm_pkg::cfg_type    cfg_ff, cfg_in;
   logic [LATENCY-1:0]   vld_ff, vld_in;
   logic [14:0]          s_eff;

   // volume path, two polarities
   logic signed [15:0]   lfo_ff, lfo_in;
   logic signed [17:0]   sum_ff [2], sum_in [2];
   logic signed [33:0]   prod_ff [2], prod_in [2];
   logic [17:0]          vol_ff [2], vol_in [2];
   logic [32:0]          mv_ff [2], mv_in [2];
   logic [28:0]          u_ff [2], u_in [2];
   logic [56:0]          sq_ff [2], sq_in [2];
   logic [28:0]          nq_ff [2], nq_in [2];
   htgm_pkg::div_type    dv_ff [htgm_pkg::DIV_STAGES][2];
   htgm_pkg::div_type    dv_in [htgm_pkg::DIV_STAGES][2];

   // crossfade
   logic [27:0]          qa_ff [2], qa_in [2];
   logic signed [28:0]   dif_ff [2], dif_in [2];
   logic [27:0]          qb_ff [2], qb_in [2];
   logic signed [44:0]   sp_ff [2], sp_in [2];
   logic signed [29:0]   vl_ff [2], vl_in [2];
   logic signed [29:0]   vr_ff [2], vr_in [2];

   // band gains
   logic signed [45:0]   pr_ff [LANES], pr_in [LANES];
   logic signed [45:0]   g_ff [LANES], g_in [LANES];
   logic [38:0]          plo_ff [LANES], plo_in [LANES];
   logic signed [41:0]   phi_ff [LANES], phi_in [LANES];
   logic signed [19:0]   out_ff [LANES], out_in [LANES];

   // tone weights
   logic [15:0]          tt_ff [2], tt_in [2];
   logic [31:0]          t2_ff [2], t2_in [2];
   logic [15:0]          tc_ff [2], tc_in [2];
   logic [47:0]          t3_ff [2], t3_in [2];
   logic [31:0]          t2b_ff [2], t2b_in [2];
   logic [16:0]          w_ff [2], w_in [2];

   assign busy = reset;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            htgm_pkg::REG_MOD_AMOUNT:    cfg_in.mod_amount    = csr_write_data[14:0];
            htgm_pkg::REG_MOD_BIAS:      cfg_in.mod_bias      = $signed(csr_write_data);
            htgm_pkg::REG_SAT_AMOUNT:    cfg_in.sat_amount    = csr_write_data[14:0];
            htgm_pkg::REG_BASS_DEPTH:    cfg_in.bass_depth    = $signed(csr_write_data);
            htgm_pkg::REG_TREBLE_DEPTH:  cfg_in.treble_depth  = $signed(csr_write_data);
            htgm_pkg::REG_TONE_BALANCE:  cfg_in.tone_balance  = $signed(csr_write_data);
            htgm_pkg::REG_STEREO_SPREAD: cfg_in.stereo_spread = csr_write_data[14:0];
            default: begin
            end
         endcase
      end
   end

   assign s_eff = (cfg_ff.sat_amount < htgm_pkg::SAT_FLOOR) ? htgm_pkg::SAT_FLOOR
                                                           : cfg_ff.sat_amount;

   assign vld_in = {vld_ff[LATENCY-2:0], start & ~busy};

   // volume per polarity, up to the divider input
   always_comb begin
      logic signed [34:0] rnd_a;
      logic signed [20:0] vt;
      logic [31:0]        m;
      logic [57:0]        nsum;
      lfo_in      = req_lfo_value;
      sum_in[POS] = 18'(cfg_ff.mod_bias) + 18'(lfo_ff);
      sum_in[NEG] = 18'(cfg_ff.mod_bias) - 18'(lfo_ff);
      for (int i = 0; i < 2; i++) begin
         prod_in[i] = 34'($signed({1'b0, cfg_ff.mod_amount})) * 34'(sum_ff[i]);
         rnd_a      = 35'(prod_ff[i]) + 35'sd8192;
         vt         = 21'(rnd_a >>> 14) + 21'sd16384;
         vol_in[i]  = vt[20] ? 18'd0 : vt[17:0];
         mv_in[i]   = 33'(vol_ff[i]) * 33'(s_eff);
         m          = mv_ff[i][32:1];
         u_in[i]    = (m > 32'(ONE_Q28)) ? 29'd0 : ONE_Q28 - m[28:0];
         sq_in[i]   = 57'(u_ff[i]) * 57'(u_ff[i]);
         // (2^56 - u^2 + s*2^27) / 2^28, the final divide by s follows
         nsum       = ONE_Q56 - 58'(sq_ff[i]) + (58'(s_eff) << 27);
         nq_in[i]   = nsum[56:28];
      end
   end

   // divider, four quotient bits per stage
   always_comb begin
      htgm_pkg::div_type init;
      for (int i = 0; i < 2; i++) begin
         init.bits   = htgm_pkg::DIV_W'(nq_ff[i]);
         init.rem    = '0;
         dv_in[0][i] = htgm_pkg::div_step(init, s_eff);
         for (int k = 1; k < htgm_pkg::DIV_STAGES; k++) begin
            dv_in[k][i] = htgm_pkg::div_step(dv_ff[k-1][i], s_eff);
         end
      end
   end

   // crossfade: left channel passes through, right channel gets the spread
   always_comb begin
      logic signed [44:0] rnd_s;
      for (int i = 0; i < 2; i++) begin
         qa_in[i] = dv_ff[htgm_pkg::DIV_STAGES-1][i].bits[27:0];
      end
      dif_in[POS] = $signed({1'b0, qa_in[NEG]}) - $signed({1'b0, qa_in[POS]});
      dif_in[NEG] = $signed({1'b0, qa_in[POS]}) - $signed({1'b0, qa_in[NEG]});
      for (int i = 0; i < 2; i++) begin
         qb_in[i] = qa_ff[i];
         sp_in[i] = 45'($signed({1'b0, cfg_ff.stereo_spread})) * 45'(dif_ff[i]);
         rnd_s    = sp_ff[i] + 45'sd8192;
         vl_in[i] = $signed({2'b00, qb_ff[i]});
         vr_in[i] = $signed({2'b00, qb_ff[i]}) + 30'(rnd_s >>> 14);
      end
   end

   // band gain lanes: bass left, bass right, treble left, treble right
   always_comb begin
      logic signed [15:0] depth;
      logic [15:0]        ad;
      logic signed [29:0] vsel;
      logic [16:0]        wsel;
      logic [21:0]        lo;
      logic signed [23:0] hi;
      logic signed [63:0] tot;
      logic signed [35:0] rr;
      for (int j = 0; j < LANES; j++) begin
         depth = (j < 2) ? cfg_ff.bass_depth : cfg_ff.treble_depth;
         wsel  = (j < 2) ? w_ff[BASS] : w_ff[TREB];
         ad    = depth[15] ? 16'(-depth) : depth;
         if ((j % 2) == 1) begin
            vsel = depth[15] ? vr_ff[NEG] : vr_ff[POS];
         end else begin
            vsel = depth[15] ? vl_ff[NEG] : vl_ff[POS];
         end
         pr_in[j]  = 46'($signed({1'b0, ad})) * 46'(vsel);
         g_in[j]   = pr_ff[j] + ((46'sd16384 - 46'($signed({1'b0, ad}))) <<< 14);
         // g*w split in two partial products
         lo        = g_ff[j][21:0];
         hi        = g_ff[j][45:22];
         plo_in[j] = 39'(lo) * 39'(wsel);
         phi_in[j] = 42'(hi) * 42'($signed({1'b0, wsel}));
         tot       = (64'(phi_ff[j]) <<< 22) + $signed(64'(plo_ff[j])) + 64'sd134217728;
         rr        = 36'(tot >>> 28);
         if (rr > 36'(OUT_MAX)) begin
            out_in[j] = OUT_MAX;
         end else if (rr < 36'(OUT_MIN)) begin
            out_in[j] = OUT_MIN;
         end else begin
            out_in[j] = rr[19:0];
         end
      end
   end

   // tone weight 1 - 3t^2 + 2t^3, from the registers only
   always_comb begin
      logic signed [48:0] wsum;
      logic [48:0]        wrnd;
      tt_in[BASS] = cfg_ff.tone_balance[15] ? 16'd0 : cfg_ff.tone_balance;
      tt_in[TREB] = cfg_ff.tone_balance[15] ? 16'(-cfg_ff.tone_balance) : 16'd0;
      for (int i = 0; i < 2; i++) begin
         t2_in[i]  = 32'(tt_ff[i]) * 32'(tt_ff[i]);
         tc_in[i]  = tt_ff[i];
         t3_in[i]  = 48'(t2_ff[i]) * 48'(tc_ff[i]);
         t2b_in[i] = t2_ff[i];
         wsum      = ONE_Q42 - ($signed(49'(t2b_ff[i]) << 15) + $signed(49'(t2b_ff[i]) << 14))
                     + $signed(49'(t3_ff[i]) << 1);
         // never negative: (1-t)^2 (1+2t)
         wrnd      = 49'(wsum) + 49'd134217728;
         w_in[i]   = 17'(wrnd >> 28);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= htgm_pkg::CFG_RESET;
         vld_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lfo_ff <= lfo_in;
      for (int i = 0; i < 2; i++) begin
         sum_ff[i]  <= sum_in[i];
         prod_ff[i] <= prod_in[i];
         vol_ff[i]  <= vol_in[i];
         mv_ff[i]   <= mv_in[i];
         u_ff[i]    <= u_in[i];
         sq_ff[i]   <= sq_in[i];
         nq_ff[i]   <= nq_in[i];
         for (int k = 0; k < htgm_pkg::DIV_STAGES; k++) begin
            dv_ff[k][i] <= dv_in[k][i];
         end
         qa_ff[i]   <= qa_in[i];
         dif_ff[i]  <= dif_in[i];
         qb_ff[i]   <= qb_in[i];
         sp_ff[i]   <= sp_in[i];
         vl_ff[i]   <= vl_in[i];
         vr_ff[i]   <= vr_in[i];
         tt_ff[i]   <= tt_in[i];
         t2_ff[i]   <= t2_in[i];
         tc_ff[i]   <= tc_in[i];
         t3_ff[i]   <= t3_in[i];
         t2b_ff[i]  <= t2b_in[i];
         w_ff[i]    <= w_in[i];
      end
      for (int j = 0; j < LANES; j++) begin
         pr_ff[j]  <= pr_in[j];
         g_ff[j]   <= g_in[j];
         plo_ff[j] <= plo_in[j];
         phi_ff[j] <= phi_in[j];
         out_ff[j] <= out_in[j];
      end
   end

   assign rsp_strobe            = vld_ff[LATENCY-1];
   assign rsp_bass_gain_left    = out_ff[0];
   assign rsp_bass_gain_right   = out_ff[1];
   assign rsp_treble_gain_left  = out_ff[2];
   assign rsp_treble_gain_right = out_ff[3];

endmodule
